/* rtl/acd_pkg.sv */
// Shared types and constants for the asset container deframer.
// Holds phase, class and status codes, register indexes and the state, config and result structs.
// Depends on nothing.
`default_nettype none

package acd_pkg;

	localparam int unsigned MAGIC_LEN = 8;
	localparam logic [20:0] LIMIT_RESET = 21'(1 << 20);

	localparam logic [3:0] PH_MAGIC   = 4'd0;
	localparam logic [3:0] PH_VERSION = 4'd1;
	localparam logic [3:0] PH_FLAGS   = 4'd2;
	localparam logic [3:0] PH_COUNT   = 4'd3;
	localparam logic [3:0] PH_STRLEN  = 4'd4;
	localparam logic [3:0] PH_STRDATA = 4'd5;
	localparam logic [3:0] PH_PAYLEN  = 4'd6;
	localparam logic [3:0] PH_PAYLOAD = 4'd7;
	localparam logic [3:0] PH_TAIL    = 4'd8;
	localparam logic [3:0] PH_ERROR   = 4'd9;

	localparam logic [2:0] CLS_HEADER  = 3'd0;
	localparam logic [2:0] CLS_LENGTH  = 3'd1;
	localparam logic [2:0] CLS_STRING  = 3'd2;
	localparam logic [2:0] CLS_PAYLOAD = 3'd3;
	localparam logic [2:0] CLS_IGNORED = 3'd4;

	localparam logic [2:0] ST_BUSY      = 3'd0;
	localparam logic [2:0] ST_ACCEPTED  = 3'd1;
	localparam logic [2:0] ST_MAGIC     = 3'd2;
	localparam logic [2:0] ST_HEADER    = 3'd3;
	localparam logic [2:0] ST_FLAGS     = 3'd4;
	localparam logic [2:0] ST_COUNT     = 3'd5;
	localparam logic [2:0] ST_POOL      = 3'd6;
	localparam logic [2:0] ST_PAYLOAD   = 3'd7;

	localparam logic [1:0] REG_MAGIC    = 2'd0;
	localparam logic [1:0] REG_MAX_POOL = 2'd1;
	localparam logic [1:0] REG_MAX_STR  = 2'd2;

	typedef struct packed {
		logic [63:0] magic;
		logic [20:0] max_pool;
		logic [20:0] max_str;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  phase;
		logic [2:0]  fbc;
		logic [23:0] shift;
		logic [20:0] pool_left;
		logic [20:0] string_left;
		logic [31:0] payload_left;
		logic [15:0] version;
		logic [19:0] string_count;
		logic [2:0]  status;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase: PH_MAGIC, fbc: 3'd0, shift: 24'd0, pool_left: 21'd0,
		string_left: 21'd0, payload_left: 32'd0, version: 16'd0,
		string_count: 20'd0, status: ST_BUSY
	};

	typedef struct packed {
		logic [7:0]  byte_out;
		logic [2:0]  byte_class;
		logic [19:0] string_index;
		logic        string_end;
		logic [15:0] version;
		logic [2:0]  status;
		logic        file_done;
	} result_t;

endpackage

`default_nettype wire

/* rtl/asset_container_deframer_unit.sv */
// Top level of the asset container deframer: input register, parser state, result register.
// Depends on acd_pkg, acd_cfg and acd_step.
//
//   channel   | handshake                | payload
//   ----------+--------------------------+---------------------------------------------
//   byte in   | byte_valid / byte_stall  | data_byte, last
//   result    | res_valid / res_stall    | byte_out, byte_class, string_index,
//             |                          | string_end, version, status, file_done
//   config    | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One byte per cycle sustained while the result is not stalled; each byte waits in the
// input register, and the result register loads from it when that register advances.
// The parser state is updated by one pass of acd_step as a byte moves from the
// input register to the result register.
// Reset empties both registers and returns the parser to the magic phase.
// A stalled result holds the input register, which then stalls the byte channel.
`default_nettype none

module asset_container_deframer_unit
	import acd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [7:0]       byte_out,
	output logic [2:0]       byte_class,
	output logic [19:0]      string_index,
	output logic             string_end,
	output logic [15:0]      version,
	output logic [2:0]       status,
	output logic             file_done,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	cfg_t    cfg;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    valid_s1;
	logic    [7:0] byte_s1;
	logic    last_s1;
	logic    res_valid_q;
	logic    adv;
	logic    load_s1;

	acd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	acd_step u_step (
		.st_cur    (state_q),
		.cfg       (cfg),
		.data_byte (byte_s1),
		.last      (last_s1),
		.st_nxt    (state_nxt),
		.res       (res_nxt)
	);

	assign adv        = valid_s1 && (!res_valid_q || !res_stall);
	assign byte_stall = valid_s1 && !adv;
	assign load_s1    = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid    = res_valid_q;
	assign byte_out     = res_q.byte_out;
	assign byte_class   = res_q.byte_class;
	assign string_index = res_q.string_index;
	assign string_end   = res_q.string_end;
	assign version      = res_q.version;
	assign status       = res_q.status;
	assign file_done    = res_q.file_done;

endmodule

`default_nettype wire

/* rtl/acd_cfg.sv */
// Configuration register bank: expected magic and the two size limits.
// Depends on acd_pkg.
`default_nettype none

module acd_cfg
	import acd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic    <= 64'd0;
			cfg_q.max_pool <= LIMIT_RESET;
			cfg_q.max_str  <= LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAGIC:    cfg_q.magic    <= cfg_data;
				REG_MAX_POOL: cfg_q.max_pool <= cfg_data[20:0];
				REG_MAX_STR:  cfg_q.max_str  <= cfg_data[20:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

endmodule

`default_nettype wire

/* rtl/acd_step.sv */
// Per-byte transition logic: next parser state and the result for one byte.
// Purely combinational; depends on acd_pkg.
`default_nettype none

module acd_step
	import acd_pkg::*;
(
	input  wire state_t      st_cur,
	input  wire cfg_t        cfg,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last,
	output state_t           st_nxt,
	output result_t          res
);

	function automatic logic [23:0] shift_in(input logic [23:0] sh, input logic [7:0] b,
			input logic [1:0] c);
		logic [23:0] r;
		r = sh;
		case (c)
			2'd0: r = sh | {16'd0, b};
			2'd1: r = sh | {8'd0, b, 8'd0};
			2'd2: r = sh | {b, 16'd0};
			default: r = sh;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] trunc_code(input logic [3:0] ph);
		logic [2:0] r;
		case (ph)
			PH_MAGIC:               r = ST_MAGIC;
			PH_VERSION, PH_FLAGS:   r = ST_HEADER;
			PH_COUNT:               r = ST_COUNT;
			PH_STRLEN, PH_STRDATA:  r = ST_POOL;
			default:                r = ST_PAYLOAD;
		endcase
		return r;
	endfunction

	state_t      nx;
	logic [2:0]  cls;
	logic [19:0] idx;
	logic        send;
	logic [31:0] v32;
	logic [15:0] v16;
	logic [20:0] sl;
	logic [20:0] pl_dec;
	logic [31:0] pay;
	logic [7:0]  exp_b;
	logic [2:0]  st;

	always_comb begin
		nx     = st_cur;
		cls    = CLS_IGNORED;
		idx    = 20'd0;
		send   = 1'b0;
		v32    = {data_byte, st_cur.shift};
		v16    = {data_byte, st_cur.shift[7:0]};
		sl     = st_cur.string_left - 21'd1;
		pl_dec = st_cur.pool_left - 21'd1;
		pay    = st_cur.payload_left - 32'd1;
		exp_b  = cfg.magic[{st_cur.fbc, 3'b000} +: 8];

		case (st_cur.phase)
			PH_MAGIC: begin
				cls = CLS_HEADER;
				if (data_byte != exp_b) begin
					nx.fbc    = 3'd0;
					nx.status = ST_MAGIC;
					nx.phase  = PH_ERROR;
				end else if (st_cur.fbc == 3'(MAGIC_LEN - 1)) begin
					nx.fbc   = 3'd0;
					nx.phase = PH_VERSION;
				end else begin
					nx.fbc = st_cur.fbc + 3'd1;
				end
			end
			PH_VERSION, PH_FLAGS: begin
				cls = CLS_HEADER;
				if (st_cur.fbc == 3'd1) begin
					nx.fbc   = 3'd0;
					nx.shift = 24'd0;
					if (st_cur.phase == PH_VERSION) begin
						nx.version = v16;
						nx.phase   = PH_FLAGS;
					end else if (v16 != 16'd0) begin
						nx.status = ST_FLAGS;
						nx.phase  = PH_ERROR;
					end else begin
						nx.phase = PH_COUNT;
					end
				end else begin
					nx.shift = shift_in(st_cur.shift, data_byte, st_cur.fbc[1:0]);
					nx.fbc   = st_cur.fbc + 3'd1;
				end
			end
			PH_COUNT, PH_STRLEN, PH_PAYLEN: begin
				cls = CLS_LENGTH;
				if (st_cur.phase == PH_STRLEN) begin
					idx = st_cur.string_count;
				end
				if (st_cur.fbc == 3'd3) begin
					nx.fbc   = 3'd0;
					nx.shift = 24'd0;
					case (st_cur.phase)
						PH_COUNT: begin
							if (v32 > {11'd0, cfg.max_pool}) begin
								nx.status = ST_COUNT;
								nx.phase  = PH_ERROR;
							end else begin
								nx.pool_left    = v32[20:0];
								nx.string_count = 20'd0;
								nx.phase        = (v32 != 32'd0) ? PH_STRLEN : PH_PAYLEN;
							end
						end
						PH_STRLEN: begin
							if (v32 > {11'd0, cfg.max_str}) begin
								nx.status = ST_POOL;
								nx.phase  = PH_ERROR;
							end else if (v32 == 32'd0) begin
								nx.string_count = st_cur.string_count + 20'd1;
								nx.pool_left    = pl_dec;
								nx.phase        = (pl_dec != 21'd0) ? PH_STRLEN : PH_PAYLEN;
							end else begin
								nx.string_left = v32[20:0];
								nx.phase       = PH_STRDATA;
							end
						end
						default: begin
							nx.payload_left = v32;
							nx.phase        = (v32 != 32'd0) ? PH_PAYLOAD : PH_TAIL;
						end
					endcase
				end else begin
					nx.shift = shift_in(st_cur.shift, data_byte, st_cur.fbc[1:0]);
					nx.fbc   = st_cur.fbc + 3'd1;
				end
			end
			PH_STRDATA: begin
				cls            = CLS_STRING;
				idx            = st_cur.string_count;
				nx.string_left = sl;
				if (sl == 21'd0) begin
					send            = 1'b1;
					nx.string_count = st_cur.string_count + 20'd1;
					nx.pool_left    = pl_dec;
					nx.phase        = (pl_dec != 21'd0) ? PH_STRLEN : PH_PAYLEN;
				end
			end
			PH_PAYLOAD: begin
				cls             = CLS_PAYLOAD;
				nx.payload_left = pay;
				if (pay == 32'd0) begin
					nx.phase = PH_TAIL;
				end
			end
			default: ;
		endcase

		st = nx.status;
		if (last && (nx.status == ST_BUSY)) begin
			st = (nx.phase == PH_TAIL) ? ST_ACCEPTED : trunc_code(nx.phase);
		end

		res.byte_out     = data_byte;
		res.byte_class   = cls;
		res.string_index = idx;
		res.string_end   = send;
		res.version      = nx.version;
		res.status       = st;
		res.file_done    = last;

		st_nxt = last ? STATE_RESET : nx;
	end

endmodule

`default_nettype wire

/* rtl/acd_checker.sv */
// Port-level checker for the asset container deframer, bound to the top level.
// Depends on acd_pkg and asset_container_deframer_unit.
`default_nettype none

module acd_checker
	import acd_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        byte_valid,
	input wire logic        byte_stall,
	input wire logic        res_valid,
	input wire logic        res_stall,
	input wire logic [2:0]  byte_class,
	input wire logic        string_end,
	input wire logic [2:0]  status,
	input wire logic        file_done
);

	logic       in_xfer;
	logic       out_xfer;
	logic [1:0] occ_q;
	logic [2:0] err_q;

	assign in_xfer  = byte_valid && !byte_stall;
	assign out_xfer = res_valid && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 2'd0;
		end else begin
			occ_q <= occ_q + 2'(in_xfer) - 2'(out_xfer);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= ST_BUSY;
		end else if (out_xfer) begin
			err_q <= file_done ? ST_BUSY : status;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q != 2'd3) && (!out_xfer || occ_q != 2'd0))
		else $error("result without a matching byte transfer");

	a_end_class: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && string_end |-> byte_class == CLS_STRING)
		else $error("string end outside string data");

	a_accept_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !file_done |-> status != ST_ACCEPTED)
		else $error("accepted status before the last byte");

	a_sticky_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && err_q != ST_BUSY |-> status == err_q && byte_class == CLS_IGNORED)
		else $error("error status not held until the last byte");

endmodule

bind asset_container_deframer_unit acd_checker u_acd_checker (.*);

`default_nettype wire
